FILE: rtl/core/bcs_pkg.sv
// Package: shared types, constants and a helper function for the bytecode CPU step block.
package bcs_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = 12;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NUM_REGS    = 16;
  localparam int NUM_KEYS    = 16;
  localparam int FONT_BYTES  = 80;
  localparam logic [ADDR_W-1:0] START_RESET = 12'd512;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_OMITTED = 2'd2
  } status_t;

  localparam logic [0:0] REG_START = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RDWAIT,
    S_FETCH_HI,
    S_FETCH_LO,
    S_FETCH_END,
    S_EXEC,
    S_BCD,
    S_SAVE,
    S_LOAD_REQ,
    S_LOAD_WAIT,
    S_DONE
  } state_t;

  // ALU operation selects for the shared byte unit
  typedef enum logic [3:0] {
    ALU_PASS_B,
    ALU_OR,
    ALU_AND,
    ALU_XOR,
    ALU_ADD,
    ALU_SUB,
    ALU_SHR,
    ALU_SUBN,
    ALU_SHL
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       flag;
  } alu_rsp_t;

  // Font glyph table, five bytes per hex digit
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] g;
    case (idx)
      7'd0: g = 8'hF0;  7'd1: g = 8'h90;  7'd2: g = 8'h90;  7'd3: g = 8'h90;
      7'd4: g = 8'hF0;  7'd5: g = 8'h20;  7'd6: g = 8'h60;  7'd7: g = 8'h20;
      7'd8: g = 8'h20;  7'd9: g = 8'h70;  7'd10: g = 8'hF0; 7'd11: g = 8'h10;
      7'd12: g = 8'hF0; 7'd13: g = 8'h80; 7'd14: g = 8'hF0; 7'd15: g = 8'hF0;
      7'd16: g = 8'h10; 7'd17: g = 8'hF0; 7'd18: g = 8'h10; 7'd19: g = 8'hF0;
      7'd20: g = 8'h90; 7'd21: g = 8'h90; 7'd22: g = 8'hF0; 7'd23: g = 8'h10;
      7'd24: g = 8'h10; 7'd25: g = 8'hF0; 7'd26: g = 8'h80; 7'd27: g = 8'hF0;
      7'd28: g = 8'h10; 7'd29: g = 8'hF0; 7'd30: g = 8'hF0; 7'd31: g = 8'h80;
      7'd32: g = 8'hF0; 7'd33: g = 8'h90; 7'd34: g = 8'hF0; 7'd35: g = 8'hF0;
      7'd36: g = 8'h10; 7'd37: g = 8'h20; 7'd38: g = 8'h40; 7'd39: g = 8'h40;
      7'd40: g = 8'hF0; 7'd41: g = 8'h90; 7'd42: g = 8'hF0; 7'd43: g = 8'h90;
      7'd44: g = 8'hF0; 7'd45: g = 8'hF0; 7'd46: g = 8'h90; 7'd47: g = 8'hF0;
      7'd48: g = 8'h10; 7'd49: g = 8'hF0; 7'd50: g = 8'hF0; 7'd51: g = 8'h90;
      7'd52: g = 8'hF0; 7'd53: g = 8'h90; 7'd54: g = 8'h90; 7'd55: g = 8'hE0;
      7'd56: g = 8'h90; 7'd57: g = 8'hE0; 7'd58: g = 8'h90; 7'd59: g = 8'hE0;
      7'd60: g = 8'hF0; 7'd61: g = 8'h80; 7'd62: g = 8'h80; 7'd63: g = 8'h80;
      7'd64: g = 8'hF0; 7'd65: g = 8'hE0; 7'd66: g = 8'h90; 7'd67: g = 8'h90;
      7'd68: g = 8'h90; 7'd69: g = 8'hE0; 7'd70: g = 8'hF0; 7'd71: g = 8'h80;
      7'd72: g = 8'hF0; 7'd73: g = 8'h80; 7'd74: g = 8'hF0; 7'd75: g = 8'hF0;
      7'd76: g = 8'h80; 7'd77: g = 8'hF0; 7'd78: g = 8'h80; 7'd79: g = 8'h80;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/bcs_in_if.sv
// Interface: input word channel of the bytecode CPU step block.
interface bcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] mem_addr;
  logic [7:0]  mem_data;
  logic [15:0] keys_pressed;
  logic [7:0]  random_byte;

  modport source (output valid, cmd, mem_addr, mem_data, keys_pressed, random_byte,
                  input ready);
  modport sink (input valid, cmd, mem_addr, mem_data, keys_pressed, random_byte,
                output ready);
endinterface

FILE: rtl/core/bcs_out_if.sv
// Interface: result word channel of the bytecode CPU step block.
interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] index_value;
  logic [15:0] opcode;
  logic [7:0]  read_data;
  logic [1:0]  status;

  modport source (output valid, program_counter, index_value, opcode, read_data, status,
                  input ready);
  modport sink (input valid, program_counter, index_value, opcode, read_data, status,
                output ready);
endinterface

FILE: rtl/core/bcs_ram.sv
// Generic single-port RAM with registered read.
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: the registered read returns the old data on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/bcs_alu.sv
// Shared byte ALU: logic, add, subtract and shift with flag.
module bcs_alu (
  input  bcs_pkg::alu_req_t req,
  output bcs_pkg::alu_rsp_t rsp
);

  logic [8:0] sum;
  logic [8:0] dif_ab;
  logic [8:0] dif_ba;

  assign sum    = {1'b0, req.a} + {1'b0, req.b};
  assign dif_ab = {1'b0, req.a} - {1'b0, req.b};
  assign dif_ba = {1'b0, req.b} - {1'b0, req.a};

  // select result and flag
  always_comb begin
    rsp.value = req.b;
    rsp.flag  = 1'b0;
    case (req.op)
      bcs_pkg::ALU_PASS_B: rsp.value = req.b;
      bcs_pkg::ALU_OR:     rsp.value = req.a | req.b;
      bcs_pkg::ALU_AND:    rsp.value = req.a & req.b;
      bcs_pkg::ALU_XOR:    rsp.value = req.a ^ req.b;
      bcs_pkg::ALU_ADD: begin
        rsp.value = sum[7:0];
        rsp.flag  = sum[8];
      end
      bcs_pkg::ALU_SUB: begin
        rsp.value = dif_ab[7:0];
        rsp.flag  = (req.a > req.b);
      end
      bcs_pkg::ALU_SHR: begin
        rsp.value = {1'b0, req.a[7:1]};
        rsp.flag  = req.a[0];
      end
      bcs_pkg::ALU_SUBN: begin
        rsp.value = dif_ba[7:0];
        rsp.flag  = (req.b > req.a);
      end
      bcs_pkg::ALU_SHL: begin
        rsp.value = {req.a[6:0], 1'b0};
        rsp.flag  = req.a[7];
      end
      default: rsp.value = req.b;
    endcase
  end

endmodule

FILE: rtl/core/bytecode_cpu_step_top.sv
// Top level: sequencer, register file, stack and memory of the bytecode CPU step block.
// One word is taken at a time and the block is not ready until its result has been
// taken. The single port of the 4096-byte memory serialises the work: an executed
// instruction makes two fetch reads, BCD store writes three bytes, block save of x+1
// registers writes one byte per cycle and block restore reads them back one at a time.
// After reset a clearing pass loads the font glyphs and zeroes the rest of memory before
// the first word is accepted. The start_address register at byte address 0 also loads
// the program counter when written.
module bytecode_cpu_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bcs_in_if.sink      in_ch,
  bcs_out_if.source   out_ch
);

  localparam int AW = bcs_pkg::ADDR_W;
  localparam int SW = bcs_pkg::SP_W;

  bcs_pkg::state_t state, state_next;

  logic [AW-1:0]  start_address;
  logic [AW-1:0]  pc;
  logic [15:0]    index_reg;
  logic [7:0]     regs [bcs_pkg::NUM_REGS];
  logic [AW-1:0]  stack [bcs_pkg::STACK_DEPTH];
  logic [SW-1:0]  sp;
  logic [7:0]     delay_value;
  logic [7:0]     sound_value;

  logic [AW-1:0]  clr_cnt;
  logic [3:0]     step;
  logic [15:0]    keys;
  logic [7:0]     rnd;
  logic [15:0]    op;
  logic [1:0]     status;
  logic [7:0]     rd_byte;
  logic [7:0]     bcd_h, bcd_t, bcd_o;

  logic           we;
  logic [AW-1:0]  maddr;
  logic [7:0]     wdata;
  logic [7:0]     rdata;

  logic           out_valid;
  logic           cfg_wr;

  bcs_pkg::alu_req_t alu_req;
  bcs_pkg::alu_rsp_t alu_rsp;

  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [7:0]  vx, vy;
  logic [AW-1:0] idx_k;

  assign ox    = op[11:8];
  assign oy    = op[7:4];
  assign on    = op[3:0];
  assign kk    = op[7:0];
  assign vx    = regs[ox];
  assign vy    = regs[oy];
  assign idx_k = index_reg[AW-1:0] + {{(AW-4){1'b0}}, step};

  bcs_ram #(.WIDTH(8), .DEPTH(bcs_pkg::MEM_BYTES)) u_mem (
    .clk  (clk),
    .we   (we),
    .addr (maddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  bcs_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == bcs_pkg::REG_START);
  assign prdata = (paddr == bcs_pkg::REG_START) ? {20'd0, start_address} : 32'd0;

  // handshake
  assign in_ch.ready      = (state == bcs_pkg::S_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.program_counter = pc;
  assign out_ch.index_value     = index_reg;
  assign out_ch.opcode          = op;
  assign out_ch.read_data       = rd_byte;
  assign out_ch.status          = status;

  // ALU operand select
  always_comb begin
    alu_req.a  = vx;
    alu_req.b  = vy;
    alu_req.op = bcs_pkg::ALU_PASS_B;
    case (on)
      4'h0: alu_req.op = bcs_pkg::ALU_PASS_B;
      4'h1: alu_req.op = bcs_pkg::ALU_OR;
      4'h2: alu_req.op = bcs_pkg::ALU_AND;
      4'h3: alu_req.op = bcs_pkg::ALU_XOR;
      4'h4: alu_req.op = bcs_pkg::ALU_ADD;
      4'h5: alu_req.op = bcs_pkg::ALU_SUB;
      4'h6: alu_req.op = bcs_pkg::ALU_SHR;
      4'h7: alu_req.op = bcs_pkg::ALU_SUBN;
      4'hE: alu_req.op = bcs_pkg::ALU_SHL;
      default: alu_req.op = bcs_pkg::ALU_PASS_B;
    endcase
    if (op[15:12] == 4'h7) begin
      alu_req.op = bcs_pkg::ALU_ADD;
      alu_req.b  = kk;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bcs_pkg::S_CLEAR:
        if (clr_cnt == AW'(bcs_pkg::MEM_BYTES - 1)) state_next = bcs_pkg::S_IDLE;
      bcs_pkg::S_IDLE:
        if (in_ch.valid) begin
          case (bcs_pkg::cmd_t'(in_ch.cmd))
            bcs_pkg::CMD_READ: state_next = bcs_pkg::S_RDWAIT;
            bcs_pkg::CMD_EXEC: state_next = bcs_pkg::S_FETCH_HI;
            default:           state_next = bcs_pkg::S_DONE;
          endcase
        end
      bcs_pkg::S_RDWAIT:    state_next = bcs_pkg::S_DONE;
      bcs_pkg::S_FETCH_HI:  state_next = bcs_pkg::S_FETCH_LO;
      bcs_pkg::S_FETCH_LO:  state_next = bcs_pkg::S_FETCH_END;
      bcs_pkg::S_FETCH_END: state_next = bcs_pkg::S_EXEC;
      bcs_pkg::S_EXEC: begin
        state_next = bcs_pkg::S_DONE;
        if (op[15:12] == 4'hF) begin
          case (kk)
            8'h33: state_next = bcs_pkg::S_BCD;
            8'h55: state_next = bcs_pkg::S_SAVE;
            8'h65: state_next = bcs_pkg::S_LOAD_REQ;
            default: state_next = bcs_pkg::S_DONE;
          endcase
        end
      end
      bcs_pkg::S_BCD:
        if (step == 4'd2) state_next = bcs_pkg::S_DONE;
      bcs_pkg::S_SAVE:
        if (step == ox) state_next = bcs_pkg::S_DONE;
      bcs_pkg::S_LOAD_REQ:  state_next = bcs_pkg::S_LOAD_WAIT;
      bcs_pkg::S_LOAD_WAIT:
        state_next = (step == ox) ? bcs_pkg::S_DONE : bcs_pkg::S_LOAD_REQ;
      bcs_pkg::S_DONE:
        if (out_valid && out_ch.ready) state_next = bcs_pkg::S_IDLE;
      default: state_next = bcs_pkg::S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    we    = 1'b0;
    maddr = pc;
    wdata = 8'd0;
    case (state)
      bcs_pkg::S_CLEAR: begin
        we    = 1'b1;
        maddr = clr_cnt;
        wdata = (clr_cnt < AW'(bcs_pkg::FONT_BYTES)) ? bcs_pkg::font_byte(clr_cnt[6:0])
                                                     : 8'd0;
      end
      bcs_pkg::S_IDLE: begin
        maddr = in_ch.mem_addr;
        we    = in_ch.valid && (in_ch.cmd == bcs_pkg::CMD_WRITE);
        wdata = in_ch.mem_data;
      end
      bcs_pkg::S_FETCH_HI: maddr = pc;
      bcs_pkg::S_FETCH_LO: maddr = pc + AW'(1);
      bcs_pkg::S_BCD: begin
        we    = 1'b1;
        maddr = idx_k;
        wdata = (step == 4'd0) ? bcd_h : ((step == 4'd1) ? bcd_t : bcd_o);
      end
      bcs_pkg::S_SAVE: begin
        we    = 1'b1;
        maddr = idx_k;
        wdata = regs[step];
      end
      bcs_pkg::S_LOAD_REQ: maddr = idx_k;
      default: maddr = pc;
    endcase
  end

  // BCD digits of Vx, small constant-divisor logic
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
    bcd_t = vx - 8'(bcd_h * 8'd100);
    bcd_o = bcd_t;
    bcd_t = 8'((16'(bcd_o) * 16'd205) >> 11);
    bcd_o = bcd_o - 8'(bcd_t * 8'd10);
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bcs_pkg::S_CLEAR;
      clr_cnt       <= '0;
      out_valid     <= 1'b0;
      start_address <= bcs_pkg::START_RESET;
      pc            <= bcs_pkg::START_RESET;
      index_reg     <= '0;
      sp            <= '0;
      delay_value   <= '0;
      sound_value   <= '0;
      step          <= '0;
      for (int i = 0; i < bcs_pkg::NUM_REGS; i++) regs[i] <= '0;
      for (int i = 0; i < bcs_pkg::STACK_DEPTH; i++) stack[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        start_address <= pwdata[AW-1:0];
        pc            <= pwdata[AW-1:0];
      end
      case (state)
        bcs_pkg::S_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        bcs_pkg::S_IDLE:
          if (in_ch.valid) begin
            keys    <= in_ch.keys_pressed;
            rnd     <= in_ch.random_byte;
            op      <= '0;
            rd_byte <= '0;
            status  <= bcs_pkg::ST_DONE;
            step    <= '0;
            if (bcs_pkg::cmd_t'(in_ch.cmd) != bcs_pkg::CMD_READ &&
                bcs_pkg::cmd_t'(in_ch.cmd) != bcs_pkg::CMD_EXEC) begin
              out_valid <= 1'b1;
            end
          end
        bcs_pkg::S_RDWAIT: begin
          rd_byte   <= rdata;
          out_valid <= 1'b1;
        end
        bcs_pkg::S_FETCH_LO:  op[15:8] <= rdata;
        bcs_pkg::S_FETCH_END: begin
          op[7:0] <= rdata;
          pc      <= pc + AW'(2);
        end
        bcs_pkg::S_EXEC: begin
          if (!(op[15:12] == 4'hF && (kk == 8'h33 || kk == 8'h55 || kk == 8'h65))) begin
            out_valid <= 1'b1;
          end
          case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) begin
                status <= bcs_pkg::ST_OMITTED;
              end else if (op == 16'h00EE) begin
                pc <= stack[sp];
                sp <= sp - SW'(1);
              end else begin
                pc <= op[11:0];
              end
            end
            4'h1: pc <= op[11:0];
            4'h2: begin
              stack[sp + SW'(1)] <= pc;
              sp <= sp + SW'(1);
              pc <= op[11:0];
            end
            4'h3: if (vx == kk) pc <= pc + AW'(2);
            4'h4: if (vx != kk) pc <= pc + AW'(2);
            4'h5: begin
              if (on != 4'h0) status <= bcs_pkg::ST_UNKNOWN;
              else if (vx == vy) pc <= pc + AW'(2);
            end
            4'h6: regs[ox] <= kk;
            4'h7: regs[ox] <= alu_rsp.value;
            4'h8: begin
              if (on <= 4'h7 || on == 4'hE) begin
                if (on != 4'h0 && on != 4'h1 && on != 4'h2 && on != 4'h3) begin
                  regs[15] <= {7'd0, alu_rsp.flag};
                end
                regs[ox] <= alu_rsp.value;
              end else begin
                status <= bcs_pkg::ST_UNKNOWN;
              end
            end
            4'h9: begin
              if (on != 4'h0) status <= bcs_pkg::ST_UNKNOWN;
              else if (vx != vy) pc <= pc + AW'(2);
            end
            4'hA: index_reg <= {4'd0, op[11:0]};
            4'hB: pc <= op[11:0] + {4'd0, regs[0]};
            4'hC: regs[ox] <= kk & rnd;
            4'hD: status <= bcs_pkg::ST_OMITTED;
            4'hE: begin
              if (kk == 8'h9E) begin
                if (vx < 8'(bcs_pkg::NUM_KEYS) && keys[vx[3:0]]) pc <= pc + AW'(2);
              end else if (kk == 8'hA1) begin
                if (vx < 8'(bcs_pkg::NUM_KEYS) && !keys[vx[3:0]]) pc <= pc + AW'(2);
              end else begin
                status <= bcs_pkg::ST_UNKNOWN;
              end
            end
            default: begin
              case (kk)
                8'h07: regs[ox] <= delay_value;
                8'h0A: status <= bcs_pkg::ST_OMITTED;
                8'h15: delay_value <= vx;
                8'h18: sound_value <= vx;
                8'h1E: index_reg <= index_reg + {8'd0, vx};
                8'h29: index_reg <= {6'd0, vx, 2'b00} + {8'd0, vx};
                8'h33, 8'h55, 8'h65: ;
                default: status <= bcs_pkg::ST_UNKNOWN;
              endcase
            end
          endcase
        end
        bcs_pkg::S_BCD: begin
          step <= step + 4'd1;
          if (step == 4'd2) out_valid <= 1'b1;
        end
        bcs_pkg::S_SAVE: begin
          step <= step + 4'd1;
          if (step == ox) out_valid <= 1'b1;
        end
        bcs_pkg::S_LOAD_WAIT: begin
          regs[step] <= rdata;
          step       <= step + 4'd1;
          if (step == ox) out_valid <= 1'b1;
        end
        bcs_pkg::S_DONE:
          if (out_ch.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result is offered only after a word was taken
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == bcs_pkg::S_DONE || state == bcs_pkg::S_IDLE))
    else $error("result valid outside done state");
  // not ready while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state == bcs_pkg::S_DONE) |-> !in_ch.ready)
    else $error("ready while result pending");
  // clear pass ends in idle
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    (state == bcs_pkg::S_CLEAR && clr_cnt == AW'(bcs_pkg::MEM_BYTES - 1))
      |=> state == bcs_pkg::S_IDLE)
    else $error("clear pass did not finish");
`endif

endmodule
